/* design/psu_pkg.sv */
// psu_pkg: constants, action codes and controller/datapath command types
// for the particle swarm update core; no dependencies
`default_nettype none
package psu_pkg;
    localparam int NumParticles = 64;
    localparam int NumDims      = 16;
    localparam int PW = $clog2(NumParticles);
    localparam int DW = $clog2(NumDims);
    localparam int AW = PW + DW;

    localparam logic [2:0] ACT_LOAD   = 3'd0;
    localparam logic [2:0] ACT_INIT   = 3'd1;
    localparam logic [2:0] ACT_UPDATE = 3'd2;
    localparam logic [2:0] ACT_EVAL   = 3'd3;
    localparam logic [2:0] ACT_READ   = 3'd4;

    localparam logic [1:0] CFG_INERTIA   = 2'd0;
    localparam logic [1:0] CFG_COGNITIVE = 2'd1;
    localparam logic [1:0] CFG_SOCIAL    = 2'd2;

    localparam logic signed [31:0] ScoreMax = 32'sh7fff_ffff;

    // commands from controller to datapath
    typedef struct packed {
        logic          capture;   // latch input word
        logic          rd_cell;   // read stores at particle/dim
        logic          wr_load;   // write loaded coord
        logic          upd_mul;   // first update stage (products)
        logic          upd_sum;   // second update stage (sum, saturate)
        logic          upd_wr;    // write back velocity/position
        logic          copy_rd;   // read position at copy index
        logic          copy_wr;   // write copied coord
        logic          score_cmp; // compare score against bests
        logic          rd_gbest;  // read global best coord
        logic          res_zero;  // result coord is zero
        logic          res_load;  // load output register
    } t_cmd;

    typedef struct packed {
        logic          p_better;
        logic          g_better;
    } t_stat;
endpackage
`default_nettype wire

/* design/psu_datapath.sv */
// psu_datapath: stores, fixed point velocity/position unit, best-score registers
// depends on psu_pkg
`default_nettype none
module psu_datapath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire psu_pkg::t_cmd     i_cmd,
    input  wire logic [2:0]        i_action,
    input  wire logic [5:0]        i_particle,
    input  wire logic [3:0]        i_dim,
    input  wire logic [31:0]       i_load_pos,
    input  wire logic [31:0]       i_load_vel,
    input  wire logic [15:0]       i_rand_c,
    input  wire logic [15:0]       i_rand_s,
    input  wire logic [31:0]       i_score,
    input  wire logic [psu_pkg::DW-1:0] i_copy_idx,
    input  wire logic              i_copy_p, // copy targets personal best
    input  wire logic              i_copy_g, // copy targets global best
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_idx,
    input  wire logic [15:0]       i_cfg_data,
    output psu_pkg::t_stat         o_stat,
    output logic [31:0]            o_coord,
    output logic                   o_pimp,
    output logic                   o_gimp,
    output logic [31:0]            o_gscore
);
    import psu_pkg::*;

    logic [31:0] pos_mem [NumParticles*NumDims];
    logic [31:0] vel_mem [NumParticles*NumDims];
    logic [31:0] pb_mem  [NumParticles*NumDims];
    logic [31:0] gb_mem  [NumDims];
    logic [31:0] ps_mem  [NumParticles];
    logic [NumParticles-1:0] r_ps_valid;

    logic [15:0] r_w, r_cg, r_sg;
    logic [2:0]  r_act;
    logic [PW-1:0] r_p;
    logic [DW-1:0] r_d;
    logic [31:0] r_lpos, r_lvel, r_score;
    logic [15:0] r_rc, r_rs;
    logic signed [31:0] r_x, r_v, r_pb, r_gb, r_ps, r_gscore, r_cp;
    logic signed [48:0] r_t0, r_t1, r_t2;
    logic signed [31:0] r_vn, r_xn;
    logic [31:0] r_coord;
    logic r_pimp, r_gimp, r_pb_flag, r_gb_flag;
    logic p_better, g_better;

    logic [AW-1:0] cell_a, copy_a;
    assign cell_a = {r_p, r_d};
    assign copy_a = {r_p, i_copy_idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= 16'd11469; r_cg <= 16'd24576; r_sg <= 16'd24576;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_INERTIA:   r_w  <= i_cfg_data;
                CFG_COGNITIVE: r_cg <= i_cfg_data;
                CFG_SOCIAL:    r_sg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act <= i_action; r_p <= i_particle[PW-1:0]; r_d <= i_dim[DW-1:0];
            r_lpos <= i_load_pos; r_lvel <= i_load_vel;
            r_rc <= i_rand_c; r_rs <= i_rand_s; r_score <= i_score;
        end
    end

    // memory reads, registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_cell) begin
            r_x  <= pos_mem[cell_a];
            r_v  <= vel_mem[cell_a];
            r_pb <= pb_mem[cell_a];
            r_gb <= gb_mem[r_d];
            r_ps <= ps_mem[r_p];
        end
        if (i_cmd.copy_rd) r_cp <= pos_mem[copy_a];
    end

    logic signed [31:0] ps_cur;
    assign ps_cur = r_ps_valid[r_p] ? r_ps : ScoreMax;
    assign p_better = $signed(r_score) < ps_cur;
    assign g_better = $signed(r_score) < r_gscore;
    assign o_stat = '{p_better: p_better, g_better: g_better};

    // memory writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_load) begin
            pos_mem[cell_a] <= r_lpos; pb_mem[cell_a] <= r_lpos; vel_mem[cell_a] <= r_lvel;
        end else if (i_cmd.upd_wr) begin
            pos_mem[cell_a] <= r_xn; vel_mem[cell_a] <= r_vn;
        end
        if (i_cmd.copy_wr && i_copy_p) pb_mem[{r_p, i_copy_idx}] <= r_cp;
        if (i_cmd.copy_wr && i_copy_g) gb_mem[i_copy_idx] <= r_cp;
        if (i_cmd.score_cmp && p_better && r_act == ACT_EVAL) ps_mem[r_p] <= r_score;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ps_valid <= '0; r_gscore <= ScoreMax; r_pb_flag <= 1'b0; r_gb_flag <= 1'b0;
        end else if (i_cmd.score_cmp) begin
            r_pb_flag <= 1'b0; r_gb_flag <= 1'b0;
            if (r_act == ACT_EVAL && p_better) begin
                r_ps_valid[r_p] <= 1'b1; r_pb_flag <= 1'b1;
                if (g_better) begin r_gscore <= r_score; r_gb_flag <= 1'b1; end
            end else if (r_act == ACT_INIT && g_better) begin
                r_gscore <= r_score; r_gb_flag <= 1'b1;
            end
        end
    end

    // gains scaled by randoms, registered during the store read
    logic [31:0] cr_full, sr_full;
    logic signed [17:0] r_cr, r_sr;
    logic signed [32:0] dp, dg;
    assign cr_full = r_cg * r_rc;
    assign sr_full = r_sg * r_rs;
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_cell) begin
            r_cr <= {2'b00, cr_full[31:16]};
            r_sr <= {2'b00, sr_full[31:16]};
        end
    end

    // update: stage 1 products
    assign dp = 33'(r_pb) - 33'(r_x);
    assign dg = 33'(r_gb) - 33'(r_x);
    logic signed [16:0] ws;
    assign ws = {1'b0, r_w};
    always_ff @(posedge i_clk) begin
        if (i_cmd.upd_mul) begin
            r_t0 <= 49'(ws * r_v);
            r_t1 <= 49'(r_cr * dp);
            r_t2 <= 49'(r_sr * dg);
        end
    end

    // stage 2: floor shifts, sum, saturate
    logic signed [36:0] vsum;
    logic signed [31:0] vsat;
    logic signed [32:0] xsum;
    always_comb begin
        vsum = 37'(r_t0 >>> 14) + 37'(r_t1 >>> 14) + 37'(r_t2 >>> 14);
        if (vsum > 37'sh7fff_ffff)       vsat = 32'sh7fff_ffff;
        else if (vsum < -37'sh8000_0000) vsat = 32'sh8000_0000;
        else                             vsat = vsum[31:0];
        xsum = 33'(r_x) + 33'(vsat);
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.upd_sum) begin
            r_vn <= vsat;
            if (xsum[32] != xsum[31]) r_xn <= xsum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            else                      r_xn <= xsum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_gbest) r_coord <= gb_mem[r_d];
        if (i_cmd.res_load) begin
            o_pimp <= r_pb_flag && r_act == ACT_EVAL;
            o_gimp <= r_gb_flag && (r_act == ACT_EVAL || r_act == ACT_INIT);
            o_gscore <= r_gscore;
            if (i_cmd.res_zero)            o_coord <= '0;
            else if (r_act == ACT_UPDATE)  o_coord <= r_xn;
            else                           o_coord <= r_coord;
        end
    end
endmodule
`default_nettype wire

/* design/psu_ctrl.sv */
// psu_ctrl: sequencer for the particle swarm update core
// depends on psu_pkg
`default_nettype none
module psu_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic [2:0]    i_action,
    input  wire logic [5:0]    i_particle,
    input  wire logic [3:0]    i_dim,
    input  wire psu_pkg::t_stat i_stat,
    output psu_pkg::t_cmd      o_cmd,
    output logic [psu_pkg::DW-1:0] o_copy_idx,
    output logic               o_copy_p,
    output logic               o_copy_g,
    output logic               o_out_valid,
    input  wire logic          i_out_ready
);
    import psu_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0, S_RD = 3'd1, S_MUL = 3'd2, S_SUM = 3'd3,
                           S_CMP = 3'd4, S_CRD = 3'd5, S_CWR = 3'd6, S_RES = 3'd7;

    logic [2:0] r_state, n_state;
    logic [2:0] r_act;
    logic       r_ok;
    logic [DW:0] r_cnt;
    logic r_cp, r_cg;
    logic r_out_valid;
    logic can_take;

    assign can_take = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_copy_idx = r_cnt[DW-1:0];
    assign o_copy_p = r_cp;
    assign o_copy_g = r_cg;

    logic acc, p_ok, d_ok;
    assign acc  = i_in_valid && o_in_ready;
    assign p_ok = 32'(i_particle) < NumParticles;
    assign d_ok = 32'(i_dim) < NumDims;

    always_comb begin
        o_cmd = '0;
        n_state = r_state;
        o_cmd.capture = acc;
        case (r_state)
            S_IDLE: if (acc) n_state = S_RD;
            S_RD: begin
                o_cmd.rd_cell = 1'b1;
                o_cmd.rd_gbest = 1'b1;
                if (r_ok && r_act == ACT_LOAD) begin
                    o_cmd.wr_load = 1'b1; n_state = S_RES;
                end else if (r_ok && r_act == ACT_UPDATE) n_state = S_MUL;
                else if (r_ok && (r_act == ACT_INIT || r_act == ACT_EVAL)) n_state = S_CMP;
                else n_state = S_RES;
            end
            S_MUL: begin o_cmd.upd_mul = 1'b1; n_state = S_SUM; end
            S_SUM: begin o_cmd.upd_sum = 1'b1; n_state = S_RES; end
            S_CMP: begin
                o_cmd.score_cmp = 1'b1;
                if ((r_act == ACT_EVAL && i_stat.p_better) ||
                    (r_act == ACT_INIT && i_stat.g_better)) n_state = S_CRD;
                else n_state = S_RES;
            end
            S_CRD: begin o_cmd.copy_rd = 1'b1; n_state = S_CWR; end
            S_CWR: begin
                o_cmd.copy_wr = 1'b1;
                n_state = (32'(r_cnt) == NumDims - 1) ? S_RES : S_CRD;
            end
            S_RES: if (can_take) begin
                o_cmd.res_load = 1'b1;
                o_cmd.res_zero = !r_ok || !(r_act == ACT_UPDATE || r_act == ACT_READ);
                o_cmd.upd_wr = r_ok && r_act == ACT_UPDATE;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_out_valid <= 1'b0;
            r_cnt <= '0; r_cp <= 1'b0; r_cg <= 1'b0; r_act <= ACT_LOAD; r_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.res_load) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
            if (acc) begin
                r_act <= i_action;
                case (i_action)
                    ACT_LOAD, ACT_UPDATE: r_ok <= p_ok && d_ok;
                    ACT_INIT, ACT_EVAL:   r_ok <= p_ok;
                    ACT_READ:             r_ok <= d_ok;
                    default:              r_ok <= 1'b0;
                endcase
            end
            if (o_cmd.score_cmp) begin
                r_cnt <= '0;
                r_cp <= r_act == ACT_EVAL;
                r_cg <= (r_act == ACT_EVAL) ? i_stat.p_better && i_stat.g_better : 1'b1;
            end else if (o_cmd.copy_wr) r_cnt <= r_cnt + 1'b1;
        end
    end

    a_copy_from_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP && n_state == S_CRD) |=> r_cnt == '0)
        else $error("copy count not cleared");
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.wr_load && o_cmd.upd_wr)) else $error("two store writes");
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid) else $error("result dropped");
endmodule
`default_nettype wire

/* design/particle_swarm_update_core.sv */
// particle_swarm_update_core: top level, controller plus datapath
// from accept to result, load/read pass the store read; update adds the
// product and sum stages; scores add the compare and, on improvement, a
// copy read and write per coordinate. One word in flight: the next is taken
// in the cycle after the result loads; a stalled result holds the input off
// reset: synchronous active low, best scores back to most positive value,
// gains to defaults; coordinate stores hold their contents
`default_nettype none
module particle_swarm_update_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // action[2:0] particle[8:3] dim_index[12:9] load_position[44:13]
    // load_velocity[76:45] rand_cognitive[92:77] rand_social[108:93] score_in[140:109]
    input  wire logic [143:0]  s_axis_tdata,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // coord_out[31:0] personal_improved[32] global_improved[33] global_best_score[65:34]
    output logic [71:0]        m_axis_tdata,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_idx,
    input  wire logic [15:0]   i_cfg_data
);
    import psu_pkg::*;

    t_cmd cmd;
    t_stat stat;
    logic [DW-1:0] copy_idx;
    logic copy_p, copy_g, pimp, gimp;
    logic [31:0] coord, gscore;

    psu_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .i_action(s_axis_tdata[2:0]), .i_particle(s_axis_tdata[8:3]),
        .i_dim(s_axis_tdata[12:9]), .i_stat(stat), .o_cmd(cmd),
        .o_copy_idx(copy_idx), .o_copy_p(copy_p), .o_copy_g(copy_g),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready)
    );

    psu_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd),
        .i_action(s_axis_tdata[2:0]), .i_particle(s_axis_tdata[8:3]),
        .i_dim(s_axis_tdata[12:9]), .i_load_pos(s_axis_tdata[44:13]),
        .i_load_vel(s_axis_tdata[76:45]), .i_rand_c(s_axis_tdata[92:77]),
        .i_rand_s(s_axis_tdata[108:93]), .i_score(s_axis_tdata[140:109]),
        .i_copy_idx(copy_idx), .i_copy_p(copy_p), .i_copy_g(copy_g),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_stat(stat), .o_coord(coord), .o_pimp(pimp), .o_gimp(gimp), .o_gscore(gscore)
    );

    assign m_axis_tdata = {6'd0, gscore, gimp, pimp, coord};
endmodule
`default_nettype wire
